>>> hw/rtl/uart_line_assembler_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line assembler queue
// Concurrent checks clocked on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef UART_LINE_ASSEMBLER_QUEUE_TOP_ASSERT_SVH
`define UART_LINE_ASSEMBLER_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define ULAQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ULAQ_ASSERT_NEVER(lbl, cond, msg) \
    `ULAQ_ASSERT(lbl, !(cond), msg)
`else
`define ULAQ_ASSERT(lbl, prop, msg)
`define ULAQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/ulaq_pkg.sv
// ----------------------------------------------------------------------------
// ulaq_pkg
// Constants, codes and types of the line assembler queue.
// ----------------------------------------------------------------------------
package ulaq_pkg;

    localparam int LINE_MAX    = 64;
    localparam int LINE_CAP    = LINE_MAX - 1;
    localparam int QUEUE_DEPTH = 8;

    // byte index within a line, also fill count (max LINE_CAP)
    localparam int IDX_W    = $clog2(LINE_MAX);
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_DEPTH = QUEUE_DEPTH * (2 ** IDX_W);

    localparam int BYTE_W    = 8;
    localparam int MAXLEN_W  = 7;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    typedef enum logic [S_TUSER_W-1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_RX_ERROR = 2'd1,
        OP_GET_LINE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_EMIT
    } state_t;

endpackage

>>> hw/rtl/ulaq_ram.sv
// ----------------------------------------------------------------------------
// ulaq_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ulaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/uart_line_assembler_queue_top.sv
// ----------------------------------------------------------------------------
// uart_line_assembler_queue_top
// Assembles received bytes into CR/LF terminated lines and queues them.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per tdata/tuser beat. tuser = operation
//   (received byte, receive error, get oldest line). Byte and error requests
//   give no result. A get gives one result per line byte, or a single empty
//   result, with m_tlast on the final one.
//   A terminator that finishes a line starts the line-buffer to queue-memory
//   copy loop, which stores the line one byte at a time. A get reads its
//   results through the registered queue memory read port and then into
//   the output register. One request is worked on at a time; s_tready is
//   low while a copy or readout is running.
//   Results sit in an output register; while m_tready is low the readout
//   pauses, and the next request is taken as soon as the last result is
//   registered.
//   Reset empties the queue and the partial line. The memories are not
//   cleared: only written entries are ever read, so no clearing pass runs.
// ----------------------------------------------------------------------------
`include "uart_line_assembler_queue_top_assert.svh"

module uart_line_assembler_queue_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] rx_byte, [14:8] max_len, [15] zero
    input  logic [ulaq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [ulaq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] char_valid, [8:1] char_out, [12:9] lines_waiting,
    // [13] line_available, [15:14] zero
    output logic [ulaq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    localparam int IDX_W = ulaq_pkg::IDX_W;
    localparam int PTR_W = ulaq_pkg::PTR_W;
    localparam int CNT_W = ulaq_pkg::CNT_W;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(ulaq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    ulaq_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             discard_reg, discard_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] slot_reg, slot_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] slot_len_reg [ulaq_pkg::QUEUE_DEPTH];

    logic                        m_valid_reg;
    logic [ulaq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;
    logic                        out_load;
    logic                        out_free;

    logic                        slen_we;
    logic                        lb_we;
    logic [IDX_W-1:0]            lb_waddr, lb_raddr;
    logic [ulaq_pkg::BYTE_W-1:0] lb_wdata, lb_rdata;
    logic                        qs_we;
    logic [PTR_W+IDX_W-1:0]      qs_waddr, qs_raddr;
    logic [ulaq_pkg::BYTE_W-1:0] qs_rdata;

    ulaq_pkg::op_t                 op;
    logic [ulaq_pkg::BYTE_W-1:0]   rx_byte;
    logic [ulaq_pkg::MAXLEN_W-1:0] max_len;
    logic [ulaq_pkg::MAXLEN_W-1:0] max_m1;
    logic [IDX_W-1:0]              slot_len;
    logic [IDX_W-1:0]              get_len;
    logic                          accept;

    assign op      = ulaq_pkg::op_t'(s_tuser);
    assign rx_byte = s_tdata[7:0];
    assign max_len = s_tdata[14:8];
    assign max_m1  = max_len - 1'b1;
    assign slot_len = slot_len_reg[tail_reg];
    assign get_len = (int'(slot_len) > int'(max_m1)) ? IDX_W'(max_m1) : slot_len;

    assign s_tready = (state_reg == ulaq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    ulaq_ram #(
        .WIDTH (ulaq_pkg::BYTE_W),
        .DEPTH (2 ** IDX_W)
    ) u_line_ram (
        .clk   (aclk),
        .we    (lb_we),
        .waddr (lb_waddr),
        .wdata (lb_wdata),
        .raddr (lb_raddr),
        .rdata (lb_rdata)
    );

    ulaq_ram #(
        .WIDTH (ulaq_pkg::BYTE_W),
        .DEPTH (ulaq_pkg::QS_DEPTH)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (qs_we),
        .waddr (qs_waddr),
        .wdata (lb_rdata),
        .raddr (qs_raddr),
        .rdata (qs_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ulaq_pkg::ST_IDLE;
            fill_reg    <= '0;
            discard_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            discard_reg <= discard_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        empty_reg <= empty_next;
        if (slen_we) begin
            slot_len_reg[head_reg] <= idx_reg;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        discard_next = discard_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        empty_next   = empty_reg;
        slen_we      = 1'b0;
        lb_we        = 1'b0;
        lb_waddr     = fill_reg;
        lb_wdata     = rx_byte;
        lb_raddr     = '0;
        qs_we        = 1'b0;
        qs_waddr     = {head_reg, idx_reg};
        out_load     = 1'b0;
        m_last_next  = 1'b1;
        m_data_next  = '0;

        unique case (state_reg)
            ulaq_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        ulaq_pkg::OP_RX_BYTE: begin
                            if (rx_byte == ulaq_pkg::CHAR_LF
                                || rx_byte == ulaq_pkg::CHAR_CR) begin
                                if (fill_reg != '0 && !discard_reg) begin
                                    idx_next   = '0;
                                    len_next   = fill_reg;
                                    state_next = ulaq_pkg::ST_COPY;
                                    // full: drop oldest line
                                    if (count_reg == CNT_W'(ulaq_pkg::QUEUE_DEPTH)) begin
                                        tail_next  = ptr_inc(tail_reg);
                                        count_next = count_reg - 1'b1;
                                    end
                                end
                                fill_next    = '0;
                                discard_next = 1'b0;
                            end else if (!discard_reg) begin
                                if (fill_reg < IDX_W'(ulaq_pkg::LINE_CAP)) begin
                                    lb_we     = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end else begin
                                    fill_next    = '0;
                                    discard_next = 1'b1;
                                end
                            end
                        end
                        ulaq_pkg::OP_RX_ERROR: begin
                            fill_next    = '0;
                            discard_next = 1'b0;
                        end
                        ulaq_pkg::OP_GET_LINE: begin
                            slot_next  = tail_reg;
                            idx_next   = '0;
                            state_next = ulaq_pkg::ST_EMIT;
                            if (max_len == '0 || count_reg == '0) begin
                                empty_next = 1'b1;
                            end else begin
                                len_next   = get_len;
                                empty_next = (get_len == '0);
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ulaq_pkg::ST_COPY: begin
                lb_raddr = idx_reg + 1'b1;
                // zero byte ends the stored content
                if (idx_reg == len_reg || lb_rdata == '0) begin
                    slen_we    = 1'b1;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg + 1'b1;
                    state_next = ulaq_pkg::ST_IDLE;
                end else begin
                    qs_we    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ulaq_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (empty_reg) begin
                        m_data_next = {2'b00, (count_reg != '0), count_reg,
                                       {ulaq_pkg::BYTE_W{1'b0}}, 1'b0};
                        m_last_next = 1'b1;
                        state_next  = ulaq_pkg::ST_IDLE;
                    end else begin
                        m_data_next = {2'b00, (count_reg != '0), count_reg,
                                       qs_rdata, 1'b1};
                        m_last_next = (idx_reg == len_reg - 1'b1);
                        if (idx_reg == len_reg - 1'b1) begin
                            state_next = ulaq_pkg::ST_IDLE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ulaq_pkg::ST_IDLE;
            end
        endcase
    end

    // next read address follows idx_next so the registered read has data ready in the next cycle
    assign qs_raddr = (state_reg == ulaq_pkg::ST_EMIT) ? {slot_reg, idx_next}
                                                       : {tail_reg, {IDX_W{1'b0}}};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `ULAQ_ASSERT_NEVER(a_count_range, count_reg > CNT_W'(ulaq_pkg::QUEUE_DEPTH),
        "queue count overflow")
    `ULAQ_ASSERT_NEVER(a_fill_range, fill_reg > IDX_W'(ulaq_pkg::LINE_CAP),
        "line fill overflow")
    `ULAQ_ASSERT(a_emit_idx,
        (state_reg == ulaq_pkg::ST_EMIT && !empty_reg) |-> (idx_reg < len_reg),
        "readout index past line length")
    `ULAQ_ASSERT(a_get_pop,
        (accept && op == ulaq_pkg::OP_GET_LINE && max_len != '0 && count_reg != '0)
        |=> (count_reg == $past(count_reg) - 1'b1),
        "get did not remove a line")
    `ULAQ_ASSERT(a_copy_push,
        (state_reg == ulaq_pkg::ST_COPY && state_next == ulaq_pkg::ST_IDLE)
        |=> (head_reg == ptr_inc($past(head_reg))),
        "line copy did not advance head")

endmodule
